// File: sv/csb_pkg.sv
// csb_pkg: shared constants for the segment-to-box clipper.
// Used by clip_segment_to_box and csb_checker; depends on nothing.
`timescale 1ns / 1ps

package csb_pkg;

    // Configuration port
    localparam int CFG_ADDR_WIDTH = 3;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_BOX_X_LOW  = 3'd0;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_BOX_Y_LOW  = 3'd1;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_BOX_X_HIGH = 3'd2;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_BOX_Y_HIGH = 3'd3;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_SCALE_EXP  = 3'd4;

    // Field widths fixed by the interface
    localparam int SCALE_WIDTH  = 6;
    localparam int STYLE_WIDTH  = 4;
    // Integer bits of the output format (range 0..512)
    localparam int OUT_INT_BITS = 10;

endpackage

// File: sv/csb_muldiv.sv
// csb_muldiv: pipelined trunc(a*b/d) with signed a, b and unsigned d, toward zero.
// Split-product multiplier followed by a one-bit-per-stage restoring divider.
// One operation per cycle when en is high; no dependencies.
`timescale 1ns / 1ps

module csb_muldiv #(
    parameter int W = 34
) (
    input  logic                clk,
    input  logic                en,
    input  logic signed [W-1:0] a,
    input  logic signed [W-1:0] b,
    input  logic signed [W-1:0] d,
    output logic signed [W-1:0] q
);

    localparam int H  = W / 2;
    localparam int LW = W - H;

    // Operand capture
    logic signed [W-1:0] a_reg;
    logic signed [W-1:0] b_reg;
    logic signed [W-1:0] d_reg;

    // Magnitudes
    logic [W-1:0] ua_reg;
    logic [W-1:0] ub_reg;
    logic [W-1:0] ud1_reg;
    logic         neg1_reg;

    // Partial products
    logic [2*H-1:0]  pp_ll_reg;
    logic [W-1:0]    pp_lh_reg;
    logic [W-1:0]    pp_hl_reg;
    logic [2*LW-1:0] pp_hh_reg;
    logic [W-1:0]    ud2_reg;
    logic            neg2_reg;

    // Divider stages; index 0 is the load stage
    logic [W-1:0] rem_reg [W+1];
    logic [W-1:0] acc_reg [W+1];
    logic [W-1:0] ud_reg  [W+1];
    logic         neg_reg [W+1];
    logic [W-1:0] rem_next [W+1];
    logic [W-1:0] acc_next [W+1];

    logic signed [W-1:0] q_reg;

    logic [W:0]     mid_sum;
    logic [2*W-1:0] product;

    // Product assembly from partial products
    always_comb
    begin
        mid_sum = (W+1)'(pp_lh_reg) + (W+1)'(pp_hl_reg);
        product = ((2*W)'(pp_hh_reg) << (2*H))
                + ((2*W)'(mid_sum) << H)
                + (2*W)'(pp_ll_reg);
    end

    // One quotient bit per stage
    always_comb
    begin
        logic [W:0] trial;
        logic       ge;
        rem_next[0] = product[2*W-1:W];
        acc_next[0] = product[W-1:0];
        for (int i = 1; i <= W; i++)
        begin
            trial = {rem_reg[i-1], acc_reg[i-1][W-1]};
            ge    = (trial >= {1'b0, ud_reg[i-1]});
            rem_next[i] = ge ? W'(trial - {1'b0, ud_reg[i-1]}) : trial[W-1:0];
            acc_next[i] = {acc_reg[i-1][W-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= a;
            b_reg <= b;
            d_reg <= d;

            ua_reg   <= a_reg[W-1] ? W'(-a_reg) : W'(a_reg);
            ub_reg   <= b_reg[W-1] ? W'(-b_reg) : W'(b_reg);
            ud1_reg  <= d_reg;
            neg1_reg <= a_reg[W-1] ^ b_reg[W-1];

            pp_ll_reg <= ua_reg[H-1:0] * ub_reg[H-1:0];
            pp_lh_reg <= W'(ua_reg[H-1:0]) * W'(ub_reg[W-1:H]);
            pp_hl_reg <= W'(ua_reg[W-1:H]) * W'(ub_reg[H-1:0]);
            pp_hh_reg <= ua_reg[W-1:H] * ub_reg[W-1:H];
            ud2_reg   <= ud1_reg;
            neg2_reg  <= neg1_reg;

            rem_reg[0] <= rem_next[0];
            acc_reg[0] <= acc_next[0];
            ud_reg[0]  <= ud2_reg;
            neg_reg[0] <= neg2_reg;
            for (int i = 1; i <= W; i++)
            begin
                rem_reg[i] <= rem_next[i];
                acc_reg[i] <= acc_next[i];
                ud_reg[i]  <= ud_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
            end

            q_reg <= neg_reg[W] ? -$signed(acc_reg[W]) : $signed(acc_reg[W]);
        end
    end

    assign q = q_reg;

endmodule

// File: sv/clip_segment_to_box.sv
// clip_segment_to_box: clips line segments to a configured box, scaled Q output.
// Depends on csb_pkg and csb_muldiv.
`timescale 1ns / 1ps

// Accepts one segment per cycle while s_tready is high and returns one result per
// segment, in order. The edge clips run one after another, each through a
// multiplier and a restoring divider that resolves one quotient bit per pipeline
// stage. The whole pipeline holds while a result waits at the output and the item
// behind it is valid; bubbles still drain. Configuration must only change while
// no segment is in flight.

module clip_segment_to_box #(
    parameter int COORD_WIDTH = 24,
    parameter int FRAC_BITS   = 8
) (
    input  logic clk,
    input  logic rst_n,

    // Segment in
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // start_x, start_y, end_x, end_y
    input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]          s_tdata,
    // style_in
    input  logic [csb_pkg::STYLE_WIDTH-1:0]             s_tuser,

    // Clipped segment out
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // out_x_a, out_y_a, out_x_b, out_y_b
    output logic [((4*(csb_pkg::OUT_INT_BITS+FRAC_BITS)+7)/8)*8-1:0] m_tdata,
    // visible, style_out
    output logic [csb_pkg::STYLE_WIDTH:0]               m_tuser,

    // Configuration writes
    input  logic                                        cfg_we,
    input  logic [csb_pkg::CFG_ADDR_WIDTH-1:0]          cfg_addr,
    input  logic [COORD_WIDTH-1:0]                      cfg_wdata
);

    localparam int CW         = COORD_WIDTH;
    localparam int F          = FRAC_BITS;
    localparam int P          = CW + 1 + F;   // box-relative fixed point
    localparam int DW         = P + 1;        // differences of fixed values
    localparam int MD_LAT     = DW + 5;       // latency of csb_muldiv
    localparam int OW         = csb_pkg::OUT_INT_BITS + F;
    localparam int SH_W       = P + 31;
    localparam int SW         = csb_pkg::STYLE_WIDTH;
    localparam int OUT_DATA_W = ((4*OW+7)/8)*8;
    localparam int N_CLIP     = 4;
    localparam int CLIP_X_LO  = 0;
    localparam int CLIP_X_HI  = 1;
    localparam int CLIP_Y_LO  = 2;
    localparam int CLIP_Y_HI  = 3;

    localparam logic [OW-1:0] OUT_MAX = {1'b1, {(OW-1){1'b0}}};

    typedef struct packed {
        logic                valid;
        logic                rej;
        logic [SW-1:0]       style;
        logic signed [P-1:0] x1;
        logic signed [P-1:0] y1;
        logic signed [P-1:0] x2;
        logic signed [P-1:0] y2;
    } seg_t;

    typedef struct packed {
        logic            valid;
        logic            rej;
        logic [SW-1:0]   style;
        logic [SH_W-1:0] xa;
        logic [SH_W-1:0] ya;
        logic [SH_W-1:0] xb;
        logic [SH_W-1:0] yb;
    } scl_t;

    // Point minus box corner, in fixed point
    function automatic logic signed [P-1:0] to_fix(input logic signed [CW-1:0] v,
                                                    input logic signed [CW-1:0] base);
        logic signed [CW:0] diff;
        diff = (CW+1)'(v) - (CW+1)'(base);
        return P'(diff) <<< F;
    endfunction

    function automatic logic [SH_W-1:0] scale_val(input logic signed [P-1:0] v,
                                                  input logic signed [csb_pkg::SCALE_WIDTH-1:0] e);
        logic [SH_W-1:0]                  u;
        logic [csb_pkg::SCALE_WIDTH-1:0]  n;
        u = SH_W'($unsigned(v));
        n = csb_pkg::SCALE_WIDTH'(-e);
        if (!e[csb_pkg::SCALE_WIDTH-1])
            return u << e[csb_pkg::SCALE_WIDTH-2:0];
        return u >> n;
    endfunction

    function automatic logic [OW-1:0] sat_out(input logic [SH_W-1:0] s);
        return (s > SH_W'(OUT_MAX)) ? OUT_MAX : OW'(s);
    endfunction

    // Configuration registers and derived limits
    logic signed [CW-1:0] box_x_low_reg;
    logic signed [CW-1:0] box_y_low_reg;
    logic signed [CW-1:0] box_x_high_reg;
    logic signed [CW-1:0] box_y_high_reg;
    logic signed [csb_pkg::SCALE_WIDTH-1:0] scale_exp_reg;
    logic signed [P-1:0] lim_x_reg;
    logic signed [P-1:0] lim_y_reg;
    logic                box_bad_reg;

    // Pipeline
    logic en;
    logic out_en;
    seg_t s1_reg, s2_reg, s3_reg, s4_reg, s5_reg, s6_reg, s7_reg, s8_reg;
    seg_t s1_next, s2_next, s3_next, s4_next, s5_next, s6_next, s7_next, s8_next;
    scl_t sc_reg, sc_next;

    logic signed [CW-1:0] sx, sy, ex, ey;
    logic                 swap_x;

    logic signed [DW-1:0] md_a [N_CLIP];
    logic signed [DW-1:0] md_b [N_CLIP];
    logic signed [DW-1:0] md_d [N_CLIP];
    logic signed [DW-1:0] md_q [N_CLIP];
    seg_t                 md_seg   [N_CLIP];
    seg_t                 md_seg_d [N_CLIP];

    // Output register
    logic          out_valid_reg;
    logic          out_visible_reg;
    logic [SW-1:0] out_style_reg;
    logic [OW-1:0] out_x_a_reg, out_y_a_reg, out_x_b_reg, out_y_b_reg;

    // Stall: the pipe moves when the output slot frees or the stage before it holds a bubble
    assign out_en   = !out_valid_reg || m_tready;
    assign en       = out_en || !sc_reg.valid;
    assign s_tready = en;

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_x_low_reg  <= '0;
            box_y_low_reg  <= '0;
            box_x_high_reg <= '0;
            box_y_high_reg <= '0;
            scale_exp_reg  <= '0;
            lim_x_reg      <= '0;
            lim_y_reg      <= '0;
            box_bad_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    csb_pkg::CFG_BOX_X_LOW:  box_x_low_reg  <= cfg_wdata;
                    csb_pkg::CFG_BOX_Y_LOW:  box_y_low_reg  <= cfg_wdata;
                    csb_pkg::CFG_BOX_X_HIGH: box_x_high_reg <= cfg_wdata;
                    csb_pkg::CFG_BOX_Y_HIGH: box_y_high_reg <= cfg_wdata;
                    csb_pkg::CFG_SCALE_EXP:
                        scale_exp_reg <= cfg_wdata[csb_pkg::SCALE_WIDTH-1:0];
                    default: ;
                endcase
            end
            lim_x_reg   <= to_fix(box_x_high_reg, box_x_low_reg);
            lim_y_reg   <= to_fix(box_y_high_reg, box_y_low_reg);
            box_bad_reg <= (box_x_high_reg < box_x_low_reg)
                        || (box_y_high_reg < box_y_low_reg);
        end
    end

    // Stage 1: order by x and translate to the box corner
    assign sx = $signed(s_tdata[CW-1:0]);
    assign sy = $signed(s_tdata[2*CW-1:CW]);
    assign ex = $signed(s_tdata[3*CW-1:2*CW]);
    assign ey = $signed(s_tdata[4*CW-1:3*CW]);
    assign swap_x = (sx > ex);

    always_comb
    begin
        s1_next.valid = s_tvalid;
        s1_next.rej   = 1'b0;
        s1_next.style = s_tuser;
        s1_next.x1    = to_fix(swap_x ? ex : sx, box_x_low_reg);
        s1_next.y1    = to_fix(swap_x ? ey : sy, box_y_low_reg);
        s1_next.x2    = to_fix(swap_x ? sx : ex, box_x_low_reg);
        s1_next.y2    = to_fix(swap_x ? sy : ey, box_y_low_reg);
    end

    // Stage 2: reject an inverted box, or a segment wholly left or right
    always_comb
    begin
        s2_next = s1_reg;
        s2_next.rej = box_bad_reg || ($signed(s1_reg.x1) > lim_x_reg) || s1_reg.x2[P-1];
    end

    // Multiply-divide operands for the edge clips
    always_comb
    begin
        md_seg[CLIP_X_LO] = s2_reg;
        md_a[CLIP_X_LO]   = -DW'($signed(s2_reg.x1));
        md_b[CLIP_X_LO]   = DW'($signed(s2_reg.y2)) - DW'($signed(s2_reg.y1));
        md_d[CLIP_X_LO]   = DW'($signed(s2_reg.x2)) - DW'($signed(s2_reg.x1));

        md_seg[CLIP_X_HI] = s3_reg;
        md_a[CLIP_X_HI]   = DW'($signed(s3_reg.x2)) - DW'(lim_x_reg);
        md_b[CLIP_X_HI]   = DW'($signed(s3_reg.y2)) - DW'($signed(s3_reg.y1));
        md_d[CLIP_X_HI]   = DW'($signed(s3_reg.x2)) - DW'($signed(s3_reg.x1));

        md_seg[CLIP_Y_LO] = s6_reg;
        md_a[CLIP_Y_LO]   = -DW'($signed(s6_reg.y1));
        md_b[CLIP_Y_LO]   = DW'($signed(s6_reg.x2)) - DW'($signed(s6_reg.x1));
        md_d[CLIP_Y_LO]   = DW'($signed(s6_reg.y2)) - DW'($signed(s6_reg.y1));

        md_seg[CLIP_Y_HI] = s7_reg;
        md_a[CLIP_Y_HI]   = DW'($signed(s7_reg.y2)) - DW'(lim_y_reg);
        md_b[CLIP_Y_HI]   = DW'($signed(s7_reg.x2)) - DW'($signed(s7_reg.x1));
        md_d[CLIP_Y_HI]   = DW'($signed(s7_reg.y2)) - DW'($signed(s7_reg.y1));
    end

    // Clip units with matching segment delay lines
    for (genvar k = 0; k < N_CLIP; k++)
    begin : g_clip
        seg_t dly_reg [MD_LAT];

        csb_muldiv #(
            .W(DW)
        ) u_muldiv (
            .clk (clk),
            .en  (en),
            .a   (md_a[k]),
            .b   (md_b[k]),
            .d   (md_d[k]),
            .q   (md_q[k])
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                for (int i = 0; i < MD_LAT; i++)
                    dly_reg[i] <= '0;
            end
            else if (en)
            begin
                dly_reg[0] <= md_seg[k];
                for (int i = 1; i < MD_LAT; i++)
                    dly_reg[i] <= dly_reg[i-1];
            end
        end

        assign md_seg_d[k] = dly_reg[MD_LAT-1];
    end

    // Apply the edge clips, reorder by y, reject against the y extent
    always_comb
    begin
        s3_next = md_seg_d[CLIP_X_LO];
        if (md_seg_d[CLIP_X_LO].x1[P-1])
        begin
            s3_next.y1 = md_seg_d[CLIP_X_LO].y1 + P'(md_q[CLIP_X_LO]);
            s3_next.x1 = '0;
        end

        s4_next = md_seg_d[CLIP_X_HI];
        if ($signed(md_seg_d[CLIP_X_HI].x2) > lim_x_reg)
        begin
            s4_next.y2 = md_seg_d[CLIP_X_HI].y2 - P'(md_q[CLIP_X_HI]);
            s4_next.x2 = lim_x_reg;
        end

        s5_next = s4_reg;
        if ($signed(s4_reg.y2) < $signed(s4_reg.y1))
        begin
            s5_next.x1 = s4_reg.x2;
            s5_next.y1 = s4_reg.y2;
            s5_next.x2 = s4_reg.x1;
            s5_next.y2 = s4_reg.y1;
        end

        s6_next = s5_reg;
        s6_next.rej = s5_reg.rej || ($signed(s5_reg.y1) > lim_y_reg) || s5_reg.y2[P-1];

        s7_next = md_seg_d[CLIP_Y_LO];
        if (md_seg_d[CLIP_Y_LO].y1[P-1])
        begin
            s7_next.x1 = md_seg_d[CLIP_Y_LO].x1 + P'(md_q[CLIP_Y_LO]);
            s7_next.y1 = '0;
        end

        s8_next = md_seg_d[CLIP_Y_HI];
        if ($signed(md_seg_d[CLIP_Y_HI].y2) > lim_y_reg)
        begin
            s8_next.x2 = md_seg_d[CLIP_Y_HI].x2 - P'(md_q[CLIP_Y_HI]);
            s8_next.y2 = lim_y_reg;
        end
    end

    // Power-of-two scale
    always_comb
    begin
        sc_next.valid = s8_reg.valid;
        sc_next.rej   = s8_reg.rej;
        sc_next.style = s8_reg.style;
        sc_next.xa    = scale_val(s8_reg.x1, scale_exp_reg);
        sc_next.ya    = scale_val(s8_reg.y1, scale_exp_reg);
        sc_next.xb    = scale_val(s8_reg.x2, scale_exp_reg);
        sc_next.yb    = scale_val(s8_reg.y2, scale_exp_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
            s3_reg <= '0;
            s4_reg <= '0;
            s5_reg <= '0;
            s6_reg <= '0;
            s7_reg <= '0;
            s8_reg <= '0;
            sc_reg <= '0;
        end
        else if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
            s6_reg <= s6_next;
            s7_reg <= s7_next;
            s8_reg <= s8_next;
            sc_reg <= sc_next;
        end
    end

    // Saturate and hold the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            out_visible_reg <= 1'b0;
            out_style_reg   <= '0;
            out_x_a_reg     <= '0;
            out_y_a_reg     <= '0;
            out_x_b_reg     <= '0;
            out_y_b_reg     <= '0;
        end
        else if (out_en)
        begin
            out_valid_reg   <= sc_reg.valid;
            out_visible_reg <= !sc_reg.rej;
            out_style_reg   <= sc_reg.style;
            out_x_a_reg     <= sc_reg.rej ? '0 : sat_out(sc_reg.xa);
            out_y_a_reg     <= sc_reg.rej ? '0 : sat_out(sc_reg.ya);
            out_x_b_reg     <= sc_reg.rej ? '0 : sat_out(sc_reg.xb);
            out_y_b_reg     <= sc_reg.rej ? '0 : sat_out(sc_reg.yb);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'({out_y_b_reg, out_x_b_reg, out_y_a_reg, out_x_a_reg});
    assign m_tuser  = {out_style_reg, out_visible_reg};

endmodule

// File: sv/csb_checker.sv
// csb_checker: port-level assertions for clip_segment_to_box, with its bind.
// Depends on csb_pkg.
`timescale 1ns / 1ps

module csb_checker #(
    parameter int FRAC_BITS   = 8
) (
    input logic clk,
    input logic rst_n,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic [((4*(csb_pkg::OUT_INT_BITS+FRAC_BITS)+7)/8)*8-1:0] m_tdata,
    input logic [csb_pkg::STYLE_WIDTH:0] m_tuser
);

    localparam int OW = csb_pkg::OUT_INT_BITS + FRAC_BITS;
    localparam logic [OW-1:0] OUT_MAX = {1'b1, {(OW-1){1'b0}}};

    logic [OW-1:0] x_a, y_a, x_b, y_b;
    logic          visible;

    assign x_a     = m_tdata[OW-1:0];
    assign y_a     = m_tdata[2*OW-1:OW];
    assign x_b     = m_tdata[3*OW-1:2*OW];
    assign y_b     = m_tdata[4*OW-1:3*OW];
    assign visible = m_tuser[0];

    // Input only stalls behind a result that is waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled with no waiting result");

    // A waiting result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("output changed while stalled");

    // Rejected segments carry zero coordinates
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !visible) |-> (x_a == '0 && y_a == '0 && x_b == '0 && y_b == '0))
        else $error("rejected segment with nonzero coordinates");

    // Lower-y endpoint comes first
    a_y_order: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && visible) |-> (y_a <= y_b))
        else $error("endpoints out of y order");

    // Saturation bound
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (x_a <= OUT_MAX && y_a <= OUT_MAX && x_b <= OUT_MAX && y_b <= OUT_MAX))
        else $error("coordinate above saturation bound");

endmodule

bind clip_segment_to_box csb_checker #(
    .FRAC_BITS  (FRAC_BITS)
) u_csb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
